[src/dual_channel_slew_limiter_assert.svh]
// Assertion macros for the dual-channel slew limiter.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef DUAL_CHANNEL_SLEW_LIMITER_ASSERT_SVH
`define DUAL_CHANNEL_SLEW_LIMITER_ASSERT_SVH

// Checked only out of reset
`define SLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define SLW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/slw_pkg.sv]
// Shared constants and types of the dual-channel slew limiter.
// No dependencies.
`default_nettype none

package slw_pkg;

  // Parameter defaults
  localparam int unsigned LEVEL_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 48;

  // Fixed field widths
  localparam int unsigned IV_BITS       = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Per-item control from top to a channel
  typedef struct packed {
    logic start;
    logic primed;
  } slw_ctl_t;

  // Direction settings shared by both channels
  typedef struct packed {
    logic               climb_en;
    logic               decay_en;
    logic [IV_BITS-1:0] climb_iv;
    logic [IV_BITS-1:0] decay_iv;
  } slw_rate_t;

endpackage

`default_nettype wire

[src/slw_if.sv]
// Handshake interfaces of the dual-channel slew limiter: input, result, config write.
// Depends on slw_pkg.
`default_nettype none

interface slw_in_if import slw_pkg::*; #(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] target_a;
  logic [LEVEL_BITS-1:0] target_b;
  logic [TIME_BITS-1:0]  time_now;

  modport source (output valid, output target_a, output target_b, output time_now,
                  input ready);
  modport sink   (input valid, input target_a, input target_b, input time_now,
                  output ready);
endinterface

interface slw_out_if import slw_pkg::*; #(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] out_a;
  logic [LEVEL_BITS-1:0] out_b;

  modport source (output valid, output out_a, output out_b, input ready);
  modport sink   (input valid, input out_a, input out_b, output ready);
endinterface

interface slw_cfg_if import slw_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  idx;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

[src/slw_chan.sv]
// One slew-limited channel: level state plus a bit-serial divider whose quotient
// bits feed a saturating MSB-first multiply. Depends on slw_pkg.
`default_nettype none

module slw_chan import slw_pkg::*; #(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slw_ctl_t              ctl_i,
  input  slw_rate_t             rate_i,
  input  logic [LEVEL_BITS-1:0] climb_step_i,
  input  logic [LEVEL_BITS-1:0] decay_step_i,
  input  logic [LEVEL_BITS-1:0] target_i,
  input  logic [TIME_BITS-1:0]  now_i,
  output logic                  busy_o,
  output logic [LEVEL_BITS-1:0] level_o
);

  localparam int unsigned CNT_W = $clog2(TIME_BITS + 1);
  localparam int unsigned ACC_W = LEVEL_BITS + 2;

  localparam logic [1:0] HEAD_NONE  = 2'd0;
  localparam logic [1:0] HEAD_CLIMB = 2'd1;
  localparam logic [1:0] HEAD_DECAY = 2'd2;

  // Control state
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [1:0]            head_q, head_d;
  logic [TIME_BITS-1:0]  st_q, st_d;
  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic                  nz_q, nz_d;

  // Datapath registers
  logic [TIME_BITS-1:0]  dsr_q, dsr_d;
  logic [IV_BITS-1:0]    rem_q, rem_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [LEVEL_BITS-1:0] need_q, need_d;
  logic [LEVEL_BITS-1:0] amt_q, amt_d;
  logic [IV_BITS-1:0]    iv_q, iv_d;
  logic                  up_q, up_d;
  logic [LEVEL_BITS-1:0] tgt_q, tgt_d;
  logic [TIME_BITS-1:0]  now_q, now_d;

  // Start decode
  logic                  up;
  logic [1:0]            dir;
  logic                  en;
  logic [IV_BITS-1:0]    iv;
  logic [LEVEL_BITS-1:0] amt;
  logic [LEVEL_BITS-1:0] need;
  logic                  jump;

  assign up   = target_i > level_q;
  assign dir  = up ? HEAD_CLIMB : HEAD_DECAY;
  assign en   = up ? rate_i.climb_en : rate_i.decay_en;
  assign iv   = up ? rate_i.climb_iv : rate_i.decay_iv;
  assign amt  = up ? climb_step_i : decay_step_i;
  assign need = up ? (target_i - level_q) : (level_q - target_i);
  assign jump = !en || (iv == '0) || (amt == '0);

  // One divider and one multiply-accumulate step
  logic                  dbit;
  logic [IV_BITS:0]      rsh;
  logic [IV_BITS:0]      rsub;
  logic                  qbit;
  logic [IV_BITS-1:0]    rem_nx;
  logic [ACC_W-1:0]      acc_nx;
  logic [TIME_BITS+IV_BITS-1:0] rem_w;
  logic [TIME_BITS-1:0]  st_fin;

  assign dbit   = dsr_q[TIME_BITS-1];
  assign rsh    = {rem_q, dbit};
  assign rsub   = rsh - {1'b0, iv_q};
  assign qbit   = rsh >= {1'b0, iv_q};
  assign rem_nx = qbit ? rsub[IV_BITS-1:0] : rsh[IV_BITS-1:0];
  assign acc_nx = {acc_q[ACC_W-2:0], 1'b0} + (qbit ? {2'b00, amt_q} : {ACC_W{1'b0}});
  assign rem_w  = {{TIME_BITS{1'b0}}, rem_q};
  // step time advances by whole intervals: now minus the remainder
  assign st_fin = now_q - rem_w[TIME_BITS-1:0];

  always_comb begin
    level_d = level_q;
    head_d  = head_q;
    st_d    = st_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    nz_d    = nz_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    need_d  = need_q;
    amt_d   = amt_q;
    iv_d    = iv_q;
    up_d    = up_q;
    tgt_d   = tgt_q;
    now_d   = now_q;

    if (busy_q) begin
      if (cnt_q != '0) begin
        // one quotient bit per cycle, MSB first
        dsr_d = {dsr_q[TIME_BITS-2:0], 1'b0};
        rem_d = rem_nx;
        cnt_d = cnt_q - 1'b1;
        if (qbit) begin
          nz_d = 1'b1;
        end
        if (!sat_q) begin
          acc_d = acc_nx;
          if (acc_nx > {2'b00, need_q}) begin
            sat_d = 1'b1;
          end
        end
      end else begin
        // finish: apply steps unless none elapsed
        busy_d = 1'b0;
        if (nz_q) begin
          st_d = st_fin;
          if (sat_q) begin
            level_d = tgt_q;
            head_d  = HEAD_NONE;
          end else begin
            level_d = up_q ? (level_q + acc_q[LEVEL_BITS-1:0])
                           : (level_q - acc_q[LEVEL_BITS-1:0]);
            if (acc_q[LEVEL_BITS-1:0] == need_q) begin
              head_d = HEAD_NONE;
            end
          end
        end
      end
    end else if (ctl_i.start) begin
      if (!ctl_i.primed) begin
        level_d = target_i;
        head_d  = HEAD_NONE;
        st_d    = now_i;
      end else if (target_i == level_q) begin
        head_d = HEAD_NONE;
      end else if (jump) begin
        level_d = target_i;
        head_d  = HEAD_NONE;
      end else if (head_q != dir) begin
        // new direction: restart the step timer, no step this beat
        head_d = dir;
        st_d   = now_i;
      end else if (now_i >= st_q) begin
        busy_d = 1'b1;
        cnt_d  = CNT_W'(TIME_BITS);
        sat_d  = 1'b0;
        nz_d   = 1'b0;
        dsr_d  = now_i - st_q;
        rem_d  = '0;
        acc_d  = '0;
        need_d = need;
        amt_d  = amt;
        iv_d   = iv;
        up_d   = up;
        tgt_d  = target_i;
        now_d  = now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      head_q  <= HEAD_NONE;
      st_q    <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      nz_q    <= 1'b0;
    end else begin
      level_q <= level_d;
      head_q  <= head_d;
      st_q    <= st_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
      nz_q    <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    need_q <= need_d;
    amt_q  <= amt_d;
    iv_q   <= iv_d;
    up_q   <= up_d;
    tgt_q  <= tgt_d;
    now_q  <= now_d;
  end

  assign busy_o  = busy_q;
  assign level_o = level_q;

endmodule

`default_nettype wire

[src/dual_channel_slew_limiter.sv]
// Top level of the dual-channel slew limiter: config registers, sequencing, result register.
// Depends on slw_pkg, slw_if, slw_chan and dual_channel_slew_limiter_assert.svh.
//
//   port    dir   beat contents
//   in_i    in    target_a, target_b, time_now
//   out_o   out   out_a, out_b
//   cfg_i   in    idx (register 0..5), data
//
// When a channel runs its divider, the result loads once the divider has produced all
// TIME_BITS quotient bits and applied the steps; the restoring divider gives one quotient
// bit a cycle. An item that copies, jumps, restarts, matches the level or carries an earlier
// timestamp skips the divider. The next beat is taken only once the result has loaded.
// Reset (async, active low) clears levels, headings, step times and registers.
// A finished result waits in the output register; the next beat is taken meanwhile.
`default_nettype none

module dual_channel_slew_limiter import slw_pkg::*; #(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  slw_in_if.sink    in_i,
  slw_out_if.source out_o,
  slw_cfg_if.sink   cfg_i
);

`include "dual_channel_slew_limiter_assert.svh"

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIMB_EN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIMB_IV = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIMB_ST = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_EN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_IV = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_ST = 3'd5;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]            state_q, state_d;
  logic                  primed_q;
  logic                  out_valid_q;
  logic [LEVEL_BITS-1:0] out_a_q, out_b_q;

  slw_rate_t             rate_q;
  logic [LEVEL_BITS-1:0] climb_step_q, decay_step_q;

  logic                  in_fire;
  logic                  busy_a, busy_b;
  logic [LEVEL_BITS-1:0] level_a, level_b;
  logic                  done;
  logic                  out_free;
  logic                  out_load;
  slw_ctl_t              ctl;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= '0;
      climb_step_q <= '0;
      decay_step_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        REG_CLIMB_EN: rate_q.climb_en <= cfg_i.data[0];
        REG_CLIMB_IV: rate_q.climb_iv <= cfg_i.data[IV_BITS-1:0];
        REG_CLIMB_ST: climb_step_q    <= cfg_i.data[LEVEL_BITS-1:0];
        REG_DECAY_EN: rate_q.decay_en <= cfg_i.data[0];
        REG_DECAY_IV: rate_q.decay_iv <= cfg_i.data[IV_BITS-1:0];
        REG_DECAY_ST: decay_step_q    <= cfg_i.data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and channel start
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign ctl.start  = in_fire;
  assign ctl.primed = primed_q;

  slw_chan #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_chan_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rate_i      (rate_q),
    .climb_step_i(climb_step_q),
    .decay_step_i(decay_step_q),
    .target_i    (in_i.target_a),
    .now_i       (in_i.time_now),
    .busy_o      (busy_a),
    .level_o     (level_a)
  );

  slw_chan #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_chan_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rate_i      (rate_q),
    .climb_step_i(climb_step_q),
    .decay_step_i(decay_step_q),
    .target_i    (in_i.target_b),
    .now_i       (in_i.time_now),
    .busy_o      (busy_b),
    .level_o     (level_b)
  );

  // Sequencer: wait for both channels, then load the result register
  assign done     = ((state_q == ST_RUN) && !busy_a && !busy_b) || (state_q == ST_HOLD);
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = done && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!busy_a && !busy_b) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        primed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_a_q <= level_a;
      out_b_q <= level_b;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_a = out_a_q;
  assign out_o.out_b = out_b_q;

  // Checks
  `SLW_ASSERT(a_no_accept_busy, in_fire |-> !(busy_a || busy_b), "beat accepted while busy")
  `SLW_ASSERT(a_idle_quiet, (state_q == ST_IDLE) |-> !(busy_a || busy_b), "channel busy in idle")
  `SLW_ASSERT(a_run_after_accept, in_fire |=> (state_q == ST_RUN), "no run after accept")
  `SLW_ASSERT_ALWAYS(a_reset_no_out, !rst_ni |-> !out_valid_q, "result valid in reset")

endmodule

`default_nettype wire
